// ----- rtl/core/mnrc_pkg.sv -----
// shared types, constants and helpers for the node renumbering block
package mnrc_pkg;

  localparam int MAX_NODES  = 65536;
  localparam int COORD_BITS = 32;

  localparam int ID_W    = 17;
  localparam int ADDR_W  = $clog2(MAX_NODES);
  localparam int SUM_W   = COORD_BITS + 3;
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 4;
  localparam int LANES   = 3;

  // centroid divider: quotient bits resolved per cycle
  localparam int DIV_STEPS  = 7;
  localparam int DIV_CYCLES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [ID_W-1:0]              id_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [COUNT_W-1:0]           count_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE2,
    KIND_TRIA3,
    KIND_QUAD4,
    KIND_TETRA4,
    KIND_PENTA6,
    KIND_HEXA8
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_WAIT,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic   start;
    count_t divisor;
  } div_req_t;

  function automatic count_t kind_nodes(input kind_t kind);
    count_t n;
    case (kind)
      KIND_LINE2:  n = COUNT_W'(2);
      KIND_TRIA3:  n = COUNT_W'(3);
      KIND_QUAD4:  n = COUNT_W'(4);
      KIND_TETRA4: n = COUNT_W'(4);
      KIND_PENTA6: n = COUNT_W'(6);
      KIND_HEXA8:  n = COUNT_W'(8);
      default:     n = COUNT_W'(8);
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/core/mnrc_if.sv -----
// handshake channels of the node renumbering block
interface mnrc_in_if;
  logic               valid;
  logic               ready;
  mnrc_pkg::id_t      node_id;
  mnrc_pkg::coord_t   coord_x;
  mnrc_pkg::coord_t   coord_y;
  mnrc_pkg::coord_t   coord_z;

  modport source (output valid, node_id, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, node_id, coord_x, coord_y, coord_z, output ready);
endinterface

interface mnrc_out_if;
  logic               valid;
  logic               ready;
  mnrc_pkg::id_t      compact_index;
  logic               first_seen;
  mnrc_pkg::id_t      distinct_total;
  logic               element_done;
  mnrc_pkg::coord_t   center_x;
  mnrc_pkg::coord_t   center_y;
  mnrc_pkg::coord_t   center_z;
  logic               id_error;

  modport source (output valid, compact_index, first_seen, distinct_total, element_done,
                  center_x, center_y, center_z, id_error, input ready);
  modport sink   (input valid, compact_index, first_seen, distinct_total, element_done,
                  center_x, center_y, center_z, id_error, output ready);
endinterface

interface mnrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mnrc_pkg::KIND_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/mnrc_cdiv.sv -----
// centroid divider: three signed sums divided by a small node count
module mnrc_cdiv (
  input  logic                 clk,
  input  logic                 rst,
  input  mnrc_pkg::div_req_t   req,
  input  mnrc_pkg::sum_t       sums [mnrc_pkg::LANES],
  output logic                 done,
  output mnrc_pkg::coord_t     quot [mnrc_pkg::LANES]
);
  import mnrc_pkg::*;

  logic                   run;
  logic [DIV_CNT_W-1:0]   cnt;
  count_t                 divisor;
  logic [DIV_W-1:0]       mag     [LANES];
  logic [SLOT_W-1:0]      rem     [LANES];
  logic                   neg     [LANES];
  logic [DIV_W-1:0]       mag_next [LANES];
  logic [SLOT_W-1:0]      rem_next [LANES];
  logic [SUM_W-1:0]       abs_in   [LANES];

  // restoring long division, DIV_STEPS quotient bits per cycle per lane
  always_comb begin
    logic [DIV_W-1:0]  m;
    logic [COUNT_W-1:0] t;
    logic [SLOT_W-1:0] r;
    for (int l = 0; l < LANES; l++) begin
      m = mag[l];
      r = rem[l];
      for (int s = 0; s < DIV_STEPS; s++) begin
        t = {r, m[DIV_W-1]};
        m = {m[DIV_W-2:0], 1'b0};
        if (t >= divisor) begin
          t    = t - divisor;
          m[0] = 1'b1;
        end
        r = t[SLOT_W-1:0];
      end
      mag_next[l] = m;
      rem_next[l] = r;
      abs_in[l]   = sums[l][SUM_W-1] ? $unsigned(-sums[l]) : $unsigned(sums[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      run <= 1'b1;
      cnt <= DIV_CNT_W'(DIV_CYCLES);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      for (int l = 0; l < LANES; l++) begin
        mag[l] <= DIV_W'(abs_in[l]);
        rem[l] <= '0;
        neg[l] <= sums[l][SUM_W-1];
      end
    end else if (run) begin
      for (int l = 0; l < LANES; l++) begin
        mag[l] <= mag_next[l];
        rem[l] <= rem_next[l];
      end
    end
  end

  // truncation toward zero: divide magnitudes, restore sign
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot[l] = neg[l] ? COORD_BITS'(-mag[l]) : COORD_BITS'(mag[l]);
    end
  end

  assign done = !run;

endmodule

// ----- rtl/core/mesh_node_renumber_centroid_top.sv -----
// top level: node renumbering through a seen map with element centroid
// result path: the seen-map read and the captured reference are registered, then the output register loads;
//   an element's last reference passes through the centroid divider (ST_DIV) before that load
// a new reference is taken only once the last one's result is loaded (seen-map read-modify-write);
//   a result not taken holds the input until the output register frees
// reset: synchronous, active high; afterwards a clearing sweep writes zero to all
//   MAX_NODES (65536) seen-map entries, one per cycle, with input ready held low
module mesh_node_renumber_centroid_top (
  input  logic       clk,
  input  logic       rst,
  mnrc_in_if.sink    node_in,
  mnrc_out_if.source result_out,
  mnrc_cfg_if.sink   cfg
);
  import mnrc_pkg::*;

  // control registers
  state_t   state, state_next;
  addr_t    clr_addr, clr_addr_next;
  kind_t    kind;
  id_t      distinct, distinct_next;
  logic [SLOT_W-1:0] slot, slot_next;
  sum_t     sum_acc [LANES];
  sum_t     sum_acc_next [LANES];
  logic     out_valid, out_valid_next;

  // captured reference
  addr_t    item_addr;
  logic     item_ok;
  coord_t   item_coord [LANES];
  logic     item_load;

  // pending result for the wait and divide states
  id_t      res_compact;
  logic     res_first;
  id_t      res_total;
  logic     res_err;
  logic     res_load;

  // output register
  id_t      out_compact;
  logic     out_first;
  id_t      out_total;
  logic     out_done;
  coord_t   out_center [LANES];
  logic     out_err;
  logic     out_load;
  logic     out_load_done;
  logic     out_from_res;

  // seen map, one write and one registered read per cycle
  id_t      seen_mem [MAX_NODES];
  id_t      mem_rdata;
  logic     mem_we;
  logic     mem_re;
  addr_t    mem_waddr;
  id_t      mem_wdata;

  // lookup-cycle values
  coord_t   in_coord [LANES];
  logic     in_ok;
  addr_t    in_addr;
  logic     look_first;
  id_t      look_total;
  id_t      look_compact;
  count_t   used;
  logic     look_done;
  logic     out_free;

  div_req_t div_req;
  logic     div_done;
  coord_t   div_quot [LANES];

  mnrc_cdiv u_cdiv (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .sums (sum_acc_next),
    .done (div_done),
    .quot (div_quot)
  );

  assign in_coord[0] = node_in.coord_x;
  assign in_coord[1] = node_in.coord_y;
  assign in_coord[2] = node_in.coord_z;

  // id zero and ids past the table are rejected
  assign in_ok   = (node_in.node_id != '0) && (32'(node_in.node_id) <= MAX_NODES);
  assign in_addr = ADDR_W'(32'(node_in.node_id) - 32'd1);

  // an entry of zero means the node has no compact number yet
  assign look_first   = item_ok && (mem_rdata == '0);
  assign look_total   = look_first ? distinct + 1'b1 : distinct;
  assign look_compact = !item_ok ? '0 : (look_first ? look_total : mem_rdata);
  assign used         = COUNT_W'(slot) + 1'b1;
  assign look_done    = used >= kind_nodes(kind);
  assign out_free     = !out_valid || result_out.ready;

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    distinct_next  = distinct;
    slot_next      = slot;
    out_valid_next = out_valid && !result_out.ready;
    item_load      = 1'b0;
    res_load       = 1'b0;
    out_load       = 1'b0;
    out_load_done  = 1'b0;
    out_from_res   = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = item_addr;
    mem_wdata      = look_total;
    node_in.ready  = 1'b0;
    div_req.start   = 1'b0;
    div_req.divisor = used;
    for (int l = 0; l < LANES; l++) begin
      sum_acc_next[l] = sum_acc[l] + SUM_W'(item_coord[l]);
    end

    case (state)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(MAX_NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        node_in.ready = 1'b1;
        if (node_in.valid) begin
          item_load  = 1'b1;
          mem_re     = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // state is committed here; the previous write has landed before the next read
        mem_we        = look_first;
        distinct_next = look_total;
        res_load      = 1'b1;
        if (look_done) begin
          slot_next     = '0;
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          slot_next = used[SLOT_W-1:0];
          if (out_free) begin
            out_load       = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_from_res   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          out_load       = 1'b1;
          out_from_res   = 1'b1;
          out_load_done  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      kind      <= KIND_TRIA3;
      distinct  <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
      for (int l = 0; l < LANES; l++) begin
        sum_acc[l] <= '0;
      end
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      distinct  <= distinct_next;
      slot      <= slot_next;
      out_valid <= out_valid_next;
      // codes past the last element kind are dropped
      if (cfg.valid && (cfg.data <= KIND_HEXA8)) begin
        kind <= kind_t'(cfg.data);
      end
      if (state == ST_LOOK) begin
        for (int l = 0; l < LANES; l++) begin
          sum_acc[l] <= look_done ? '0 : sum_acc_next[l];
        end
      end
    end
  end

  assign cfg.ready = 1'b1;

  // payload registers
  always_ff @(posedge clk) begin
    if (item_load) begin
      item_addr <= in_addr;
      item_ok   <= in_ok;
      for (int l = 0; l < LANES; l++) begin
        item_coord[l] <= in_coord[l];
      end
    end
    if (res_load) begin
      res_compact <= look_compact;
      res_first   <= look_first;
      res_total   <= look_total;
      res_err     <= !item_ok;
    end
    if (out_load) begin
      out_compact <= out_from_res ? res_compact : look_compact;
      out_first   <= out_from_res ? res_first : look_first;
      out_total   <= out_from_res ? res_total : look_total;
      out_err     <= out_from_res ? res_err : !item_ok;
      out_done    <= out_load_done;
      for (int l = 0; l < LANES; l++) begin
        out_center[l] <= out_load_done ? div_quot[l] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= seen_mem[in_addr];
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.compact_index  = out_compact;
  assign result_out.first_seen     = out_first;
  assign result_out.distinct_total = out_total;
  assign result_out.element_done   = out_done;
  assign result_out.center_x       = out_center[0];
  assign result_out.center_y       = out_center[1];
  assign result_out.center_z       = out_center[2];
  assign result_out.id_error       = out_err;

  // a newly numbered node takes the running count as its number
  a_first_total: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.first_seen |->
      result_out.compact_index == result_out.distinct_total)
    else $error("first-seen result with compact index apart from distinct total");

  // a rejected id is never mapped
  a_err_unmapped: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.id_error |->
      result_out.compact_index == '0 && !result_out.first_seen)
    else $error("rejected id carries a mapping");

  // every input transfer is followed by the seen-map lookup cycle
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    node_in.valid && node_in.ready |=> state == ST_LOOK)
    else $error("input transfer not followed by lookup");

  // the seen map is written only by the sweep or a first sighting
  a_map_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_CLEAR || (state == ST_LOOK && item_ok))
    else $error("seen map written outside sweep or lookup");

endmodule
